// ===== rtl/tcc_pkg.sv =====
// tcc_pkg: shared types for the triangle circumcircle pipeline
// no dependencies; used by tcc_div, tcc_sqrt and triangle_circumcircle
package tcc_pkg;

    // pipeline control that travels from the top level into each unit
    typedef struct packed {
        logic valid;
        logic en;
    } tcc_ctrl_t;

endpackage

// ===== rtl/tcc_div.sv =====
// tcc_div: pipelined truncating signed divider for the two center numerators
// one quotient bit per stage, saturates to the signed W-bit range; uses tcc_pkg
module tcc_div #(
    parameter int W    = 32,
    parameter int TAGW = 1
) (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  tcc_pkg::tcc_ctrl_t      ctrl,
    input  logic signed [3*W+2:0]   num_x,
    input  logic signed [3*W+2:0]   num_y,
    input  logic signed [2*W+3:0]   den,
    input  logic        [TAGW-1:0]  in_tag,
    output logic                    out_valid,
    output logic signed [W-1:0]     quo_x,
    output logic signed [W-1:0]     quo_y,
    output logic        [TAGW-1:0]  out_tag
);

    localparam int NW = 3 * W + 3;
    localparam int DW = 2 * W + 4;
    localparam int RW = 3 * W + 5;
    localparam int QB = W + 1;
    localparam logic [QB-1:0] POS_LIM = QB'((64'd1 << (W - 1)) - 64'd1);
    localparam logic [QB-1:0] NEG_LIM = QB'(64'd1 << (W - 1));
    localparam logic [W-1:0]  MAX_VAL = {1'b0, {(W - 1){1'b1}}};
    localparam logic [W-1:0]  MIN_VAL = {1'b1, {(W - 1){1'b0}}};

    logic [NW-1:0] mag_nx;
    logic [NW-1:0] mag_ny;
    logic [DW-1:0] mag_d;

    logic            va_reg;
    logic [RW-1:0]   ax_reg, ay_reg, ad_reg;
    logic            sx_reg, sy_reg;
    logic [TAGW-1:0] tga_reg;

    logic            v_reg   [QB+1];
    logic [RW-1:0]   rx_reg  [QB+1];
    logic [RW-1:0]   ry_reg  [QB+1];
    logic [RW-1:0]   rd_reg  [QB+1];
    logic [QB-1:0]   qx_reg  [QB+1];
    logic [QB-1:0]   qy_reg  [QB+1];
    logic            ox_reg  [QB+1];
    logic            oy_reg  [QB+1];
    logic            sxp_reg [QB+1];
    logic            syp_reg [QB+1];
    logic [TAGW-1:0] tg_reg  [QB+1];

    logic [RW-1:0]   rx_next  [QB+1];
    logic [RW-1:0]   ry_next  [QB+1];
    logic [RW-1:0]   rd_next  [QB+1];
    logic [QB-1:0]   qx_next  [QB+1];
    logic [QB-1:0]   qy_next  [QB+1];
    logic            ox_next  [QB+1];
    logic            oy_next  [QB+1];
    logic            sxp_next [QB+1];
    logic            syp_next [QB+1];
    logic [TAGW-1:0] tg_next  [QB+1];

    logic              vo_reg;
    logic signed [W-1:0] qox_reg, qoy_reg;
    logic [TAGW-1:0]   tgo_reg;
    logic [W-1:0]      qox_next, qoy_next;
    logic [QB-1:0]     negq_x, negq_y;

    // magnitudes and quotient sign
    assign mag_nx = num_x[NW-1] ? (~num_x + 1'b1) : num_x;
    assign mag_ny = num_y[NW-1] ? (~num_y + 1'b1) : num_y;
    assign mag_d  = den[DW-1]   ? (~den + 1'b1)   : den;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            va_reg <= 1'b0;
        end else if (ctrl.en) begin
            va_reg <= ctrl.valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (ctrl.en) begin
            ax_reg  <= RW'(mag_nx);
            ay_reg  <= RW'(mag_ny);
            ad_reg  <= RW'(mag_d);
            sx_reg  <= num_x[NW-1] ^ den[DW-1];
            sy_reg  <= num_y[NW-1] ^ den[DW-1];
            tga_reg <= in_tag;
        end
    end

    // restoring division, bit QB-1-k decided in stage k+1
    always_comb begin
        logic [RW-1:0] dsh;
        rx_next[0]  = ax_reg;
        ry_next[0]  = ay_reg;
        rd_next[0]  = ad_reg;
        qx_next[0]  = '0;
        qy_next[0]  = '0;
        ox_next[0]  = (ax_reg >= (ad_reg << QB));
        oy_next[0]  = (ay_reg >= (ad_reg << QB));
        sxp_next[0] = sx_reg;
        syp_next[0] = sy_reg;
        tg_next[0]  = tga_reg;
        for (int k = 0; k < QB; k++) begin
            dsh = rd_reg[k] << (QB - 1 - k);
            rx_next[k+1] = rx_reg[k];
            qx_next[k+1] = qx_reg[k];
            if (rx_reg[k] >= dsh) begin
                rx_next[k+1] = rx_reg[k] - dsh;
                qx_next[k+1] = qx_reg[k] | (QB'(1) << (QB - 1 - k));
            end
            ry_next[k+1] = ry_reg[k];
            qy_next[k+1] = qy_reg[k];
            if (ry_reg[k] >= dsh) begin
                ry_next[k+1] = ry_reg[k] - dsh;
                qy_next[k+1] = qy_reg[k] | (QB'(1) << (QB - 1 - k));
            end
            rd_next[k+1]  = rd_reg[k];
            ox_next[k+1]  = ox_reg[k];
            oy_next[k+1]  = oy_reg[k];
            sxp_next[k+1] = sxp_reg[k];
            syp_next[k+1] = syp_reg[k];
            tg_next[k+1]  = tg_reg[k];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int k = 0; k <= QB; k++) begin
                v_reg[k] <= 1'b0;
            end
        end else if (ctrl.en) begin
            v_reg[0] <= va_reg;
            for (int k = 0; k < QB; k++) begin
                v_reg[k+1] <= v_reg[k];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (ctrl.en) begin
            rx_reg  <= rx_next;
            ry_reg  <= ry_next;
            rd_reg  <= rd_next;
            qx_reg  <= qx_next;
            qy_reg  <= qy_next;
            ox_reg  <= ox_next;
            oy_reg  <= oy_next;
            sxp_reg <= sxp_next;
            syp_reg <= syp_next;
            tg_reg  <= tg_next;
        end
    end

    // sign and saturation
    assign negq_x = ~qx_reg[QB] + 1'b1;
    assign negq_y = ~qy_reg[QB] + 1'b1;

    always_comb begin
        if (sxp_reg[QB]) begin
            qox_next = (ox_reg[QB] || qx_reg[QB] > NEG_LIM) ? MIN_VAL : negq_x[W-1:0];
        end else begin
            qox_next = (ox_reg[QB] || qx_reg[QB] > POS_LIM) ? MAX_VAL : qx_reg[QB][W-1:0];
        end
        if (syp_reg[QB]) begin
            qoy_next = (oy_reg[QB] || qy_reg[QB] > NEG_LIM) ? MIN_VAL : negq_y[W-1:0];
        end else begin
            qoy_next = (oy_reg[QB] || qy_reg[QB] > POS_LIM) ? MAX_VAL : qy_reg[QB][W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vo_reg <= 1'b0;
        end else if (ctrl.en) begin
            vo_reg <= v_reg[QB];
        end
    end

    always_ff @(posedge aclk) begin
        if (ctrl.en) begin
            qox_reg <= qox_next;
            qoy_reg <= qoy_next;
            tgo_reg <= tg_reg[QB];
        end
    end

    assign out_valid = vo_reg;
    assign quo_x     = qox_reg;
    assign quo_y     = qoy_reg;
    assign out_tag   = tgo_reg;

endmodule

// ===== rtl/tcc_sqrt.sv =====
// tcc_sqrt: pipelined floor square root, one root bit per stage
// uses tcc_pkg for the pipeline control
module tcc_sqrt #(
    parameter int W    = 32,
    parameter int TAGW = 1
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  tcc_pkg::tcc_ctrl_t     ctrl,
    input  logic [2*W+1:0]         radicand,
    input  logic [TAGW-1:0]        in_tag,
    output logic                   out_valid,
    output logic [W:0]             root,
    output logic [TAGW-1:0]        out_tag
);

    localparam int RSW = 2 * W + 2;
    localparam int TW  = 2 * W + 3;
    localparam int SB  = W + 1;

    logic            v_reg    [SB];
    logic [RSW-1:0]  rem_reg  [SB];
    logic [SB-1:0]   root_reg [SB];
    logic [TAGW-1:0] tag_reg  [SB];

    logic [RSW-1:0]  rem_next  [SB];
    logic [SB-1:0]   root_next [SB];
    logic [TAGW-1:0] tag_next  [SB];

    // remainder holds radicand minus root squared
    always_comb begin
        logic [RSW-1:0] rin;
        logic [SB-1:0]  qin;
        logic [TW-1:0]  trial;
        for (int k = 0; k < SB; k++) begin
            if (k == 0) begin
                rin         = radicand;
                qin         = '0;
                tag_next[k] = in_tag;
            end else begin
                rin         = rem_reg[k-1];
                qin         = root_reg[k-1];
                tag_next[k] = tag_reg[k-1];
            end
            trial = (TW'(qin) << (SB - k)) | (TW'(1) << (2 * (SB - 1 - k)));
            rem_next[k]  = rin;
            root_next[k] = qin;
            if (TW'(rin) >= trial) begin
                rem_next[k]  = RSW'(TW'(rin) - trial);
                root_next[k] = qin | (SB'(1) << (SB - 1 - k));
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int k = 0; k < SB; k++) begin
                v_reg[k] <= 1'b0;
            end
        end else if (ctrl.en) begin
            v_reg[0] <= ctrl.valid;
            for (int k = 1; k < SB; k++) begin
                v_reg[k] <= v_reg[k-1];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (ctrl.en) begin
            rem_reg  <= rem_next;
            root_reg <= root_next;
            tag_reg  <= tag_next;
        end
    end

    assign out_valid = v_reg[SB-1];
    assign root      = root_reg[SB-1];
    assign out_tag   = tag_reg[SB-1];

endmodule

// ===== rtl/triangle_circumcircle.sv =====
// triangle_circumcircle: circumcenter and radius of one triangle per cycle while the output is not stalled
// throughput: one word per cycle when not stalled; the divider and square root resolve one bit per stage
// the pipeline stalls only while a result waits at the output and its last stage is full
// reset: synchronous active-low aresetn clears all valid bits, data registers keep their values
// depends on tcc_pkg, tcc_div and tcc_sqrt
module triangle_circumcircle #(
    parameter int COORD_WIDTH = 32
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic signed [COORD_WIDTH-1:0] s_vertex0_x,
    input  logic signed [COORD_WIDTH-1:0] s_vertex0_y,
    input  logic signed [COORD_WIDTH-1:0] s_vertex1_x,
    input  logic signed [COORD_WIDTH-1:0] s_vertex1_y,
    input  logic signed [COORD_WIDTH-1:0] s_vertex2_x,
    input  logic signed [COORD_WIDTH-1:0] s_vertex2_y,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic signed [COORD_WIDTH-1:0] m_center_x,
    output logic signed [COORD_WIDTH-1:0] m_center_y,
    output logic        [COORD_WIDTH-1:0] m_radius,
    output logic                          m_degenerate
);

    localparam int W   = COORD_WIDTH;
    localparam int SQ  = 2 * W;
    localparam int DP  = 2 * W + 1;
    localparam int DW  = 2 * W + 4;
    localparam int PP  = 2 * W + 2;
    localparam int NW  = 3 * W + 3;
    localparam int RSW = 2 * W + 2;
    localparam int TGW = 2 * W + 1;

    logic en;
    tcc_pkg::tcc_ctrl_t div_ctrl, sqrt_ctrl;

    // stage 1: coordinates and edge differences
    logic                v1_reg;
    logic signed [W-1:0] x_s1_reg  [3];
    logic signed [W-1:0] y_s1_reg  [3];
    logic signed [W:0]   dy_s1_reg [3];
    logic signed [W:0]   dx_s1_reg [3];

    // stage 2: squares and area products
    logic                 v2_reg;
    logic signed [SQ-1:0] xx_s2_reg [3];
    logic signed [SQ-1:0] yy_s2_reg [3];
    logic signed [DP-1:0] dp_s2_reg [3];
    logic signed [W:0]    dy_s2_reg [3];
    logic signed [W:0]    dx_s2_reg [3];
    logic signed [W-1:0]  x0_s2_reg, y0_s2_reg;

    // stage 3: squared norms and denominator
    logic                 v3_reg;
    logic        [SQ-1:0] s_s3_reg  [3];
    logic signed [DW-1:0] d_s3_reg;
    logic signed [W:0]    dy_s3_reg [3];
    logic signed [W:0]    dx_s3_reg [3];
    logic signed [W-1:0]  x0_s3_reg, y0_s3_reg;

    // stage 4: half-width partial products
    logic                 v4_reg;
    logic signed [PP-1:0] plx_s4_reg [3];
    logic signed [PP-1:0] phx_s4_reg [3];
    logic signed [PP-1:0] ply_s4_reg [3];
    logic signed [PP-1:0] phy_s4_reg [3];
    logic signed [DW-1:0] d_s4_reg;
    logic                 deg_s4_reg;
    logic signed [W-1:0]  x0_s4_reg, y0_s4_reg;

    // stage 5: full products
    logic                 v5_reg;
    logic signed [NW-1:0] cx_s5_reg [3];
    logic signed [NW-1:0] cy_s5_reg [3];
    logic signed [DW-1:0] d_s5_reg;
    logic                 deg_s5_reg;
    logic signed [W-1:0]  x0_s5_reg, y0_s5_reg;

    // stage 6: numerators
    logic                 v6_reg;
    logic signed [NW-1:0] nx_s6_reg, ny_s6_reg;
    logic signed [DW-1:0] d_s6_reg;
    logic                 deg_s6_reg;
    logic signed [W-1:0]  x0_s6_reg, y0_s6_reg;

    logic                 div_valid;
    logic signed [W-1:0]  div_cx, div_cy;
    logic [TGW-1:0]       div_tag;

    // radius stages
    logic                 ve1_reg, ve2_reg, ve3_reg;
    logic signed [W:0]    ex_e1_reg, ey_e1_reg;
    logic signed [PP-1:0] exx_e2_reg, eyy_e2_reg;
    logic [RSW-1:0]       rs_e3_reg;
    logic [TGW-1:0]       tg_e1_reg, tg_e2_reg, tg_e3_reg;

    logic                 sq_valid;
    logic [W:0]           sq_root;
    logic [TGW-1:0]       sq_tag;

    logic                 m_valid_reg;
    logic signed [W-1:0]  m_center_x_reg, m_center_y_reg;
    logic [W-1:0]         m_radius_reg;
    logic                 m_degenerate_reg;

    assign en      = !m_valid_reg || m_ready || !sq_valid;
    assign s_ready = en;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg  <= 1'b0;
            v2_reg  <= 1'b0;
            v3_reg  <= 1'b0;
            v4_reg  <= 1'b0;
            v5_reg  <= 1'b0;
            v6_reg  <= 1'b0;
            ve1_reg <= 1'b0;
            ve2_reg <= 1'b0;
            ve3_reg <= 1'b0;
        end else if (en) begin
            v1_reg  <= s_valid;
            v2_reg  <= v1_reg;
            v3_reg  <= v2_reg;
            v4_reg  <= v3_reg;
            v5_reg  <= v4_reg;
            v6_reg  <= v5_reg;
            ve1_reg <= div_valid;
            ve2_reg <= ve1_reg;
            ve3_reg <= ve2_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            x_s1_reg[0]  <= s_vertex0_x;
            x_s1_reg[1]  <= s_vertex1_x;
            x_s1_reg[2]  <= s_vertex2_x;
            y_s1_reg[0]  <= s_vertex0_y;
            y_s1_reg[1]  <= s_vertex1_y;
            y_s1_reg[2]  <= s_vertex2_y;
            dy_s1_reg[0] <= (W + 1)'(s_vertex1_y) - (W + 1)'(s_vertex2_y);
            dy_s1_reg[1] <= (W + 1)'(s_vertex2_y) - (W + 1)'(s_vertex0_y);
            dy_s1_reg[2] <= (W + 1)'(s_vertex0_y) - (W + 1)'(s_vertex1_y);
            dx_s1_reg[0] <= (W + 1)'(s_vertex2_x) - (W + 1)'(s_vertex1_x);
            dx_s1_reg[1] <= (W + 1)'(s_vertex0_x) - (W + 1)'(s_vertex2_x);
            dx_s1_reg[2] <= (W + 1)'(s_vertex1_x) - (W + 1)'(s_vertex0_x);

            for (int i = 0; i < 3; i++) begin
                xx_s2_reg[i] <= SQ'(x_s1_reg[i]) * SQ'(x_s1_reg[i]);
                yy_s2_reg[i] <= SQ'(y_s1_reg[i]) * SQ'(y_s1_reg[i]);
                dp_s2_reg[i] <= DP'(x_s1_reg[i]) * DP'(dy_s1_reg[i]);
            end
            dy_s2_reg <= dy_s1_reg;
            dx_s2_reg <= dx_s1_reg;
            x0_s2_reg <= x_s1_reg[0];
            y0_s2_reg <= y_s1_reg[0];

            for (int i = 0; i < 3; i++) begin
                s_s3_reg[i] <= $unsigned(xx_s2_reg[i]) + $unsigned(yy_s2_reg[i]);
            end
            d_s3_reg  <= (DW'(dp_s2_reg[0]) + DW'(dp_s2_reg[1]) + DW'(dp_s2_reg[2])) <<< 1;
            dy_s3_reg <= dy_s2_reg;
            dx_s3_reg <= dx_s2_reg;
            x0_s3_reg <= x0_s2_reg;
            y0_s3_reg <= y0_s2_reg;

            for (int i = 0; i < 3; i++) begin
                plx_s4_reg[i] <= PP'($signed({1'b0, s_s3_reg[i][W-1:0]})) * PP'(dy_s3_reg[i]);
                phx_s4_reg[i] <= PP'($signed({1'b0, s_s3_reg[i][SQ-1:W]})) * PP'(dy_s3_reg[i]);
                ply_s4_reg[i] <= PP'($signed({1'b0, s_s3_reg[i][W-1:0]})) * PP'(dx_s3_reg[i]);
                phy_s4_reg[i] <= PP'($signed({1'b0, s_s3_reg[i][SQ-1:W]})) * PP'(dx_s3_reg[i]);
            end
            d_s4_reg   <= d_s3_reg;
            deg_s4_reg <= (d_s3_reg == '0);
            x0_s4_reg  <= x0_s3_reg;
            y0_s4_reg  <= y0_s3_reg;

            for (int i = 0; i < 3; i++) begin
                cx_s5_reg[i] <= (NW'(phx_s4_reg[i]) <<< W) + NW'(plx_s4_reg[i]);
                cy_s5_reg[i] <= (NW'(phy_s4_reg[i]) <<< W) + NW'(ply_s4_reg[i]);
            end
            d_s5_reg   <= d_s4_reg;
            deg_s5_reg <= deg_s4_reg;
            x0_s5_reg  <= x0_s4_reg;
            y0_s5_reg  <= y0_s4_reg;

            nx_s6_reg  <= cx_s5_reg[0] + cx_s5_reg[1] + cx_s5_reg[2];
            ny_s6_reg  <= cy_s5_reg[0] + cy_s5_reg[1] + cy_s5_reg[2];
            d_s6_reg   <= d_s5_reg;
            deg_s6_reg <= deg_s5_reg;
            x0_s6_reg  <= x0_s5_reg;
            y0_s6_reg  <= y0_s5_reg;
        end
    end

    assign div_ctrl = '{valid: v6_reg, en: en};

    tcc_div #(
        .W    (W),
        .TAGW (TGW)
    ) u_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .ctrl      (div_ctrl),
        .num_x     (nx_s6_reg),
        .num_y     (ny_s6_reg),
        .den       (d_s6_reg),
        .in_tag    ({x0_s6_reg, y0_s6_reg, deg_s6_reg}),
        .out_valid (div_valid),
        .quo_x     (div_cx),
        .quo_y     (div_cy),
        .out_tag   (div_tag)
    );

    // distance from the center to the first vertex
    always_ff @(posedge aclk) begin
        if (en) begin
            ex_e1_reg  <= (W + 1)'(div_cx) - (W + 1)'($signed(div_tag[TGW-1:W+1]));
            ey_e1_reg  <= (W + 1)'(div_cy) - (W + 1)'($signed(div_tag[W:1]));
            tg_e1_reg  <= {div_cx, div_cy, div_tag[0]};

            exx_e2_reg <= PP'(ex_e1_reg) * PP'(ex_e1_reg);
            eyy_e2_reg <= PP'(ey_e1_reg) * PP'(ey_e1_reg);
            tg_e2_reg  <= tg_e1_reg;

            rs_e3_reg  <= $unsigned(exx_e2_reg) + $unsigned(eyy_e2_reg);
            tg_e3_reg  <= tg_e2_reg;
        end
    end

    assign sqrt_ctrl = '{valid: ve3_reg, en: en};

    tcc_sqrt #(
        .W    (W),
        .TAGW (TGW)
    ) u_sqrt (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .ctrl      (sqrt_ctrl),
        .radicand  (rs_e3_reg),
        .in_tag    (tg_e3_reg),
        .out_valid (sq_valid),
        .root      (sq_root),
        .out_tag   (sq_tag)
    );

    // output word register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (en && sq_valid) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (en && sq_valid) begin
            if (sq_tag[0]) begin
                m_center_x_reg   <= '0;
                m_center_y_reg   <= '0;
                m_radius_reg     <= '0;
                m_degenerate_reg <= 1'b1;
            end else begin
                m_center_x_reg   <= $signed(sq_tag[TGW-1:W+1]);
                m_center_y_reg   <= $signed(sq_tag[W:1]);
                m_radius_reg     <= sq_root[W] ? {W{1'b1}} : sq_root[W-1:0];
                m_degenerate_reg <= 1'b0;
            end
        end
    end

    assign m_valid      = m_valid_reg;
    assign m_center_x   = m_center_x_reg;
    assign m_center_y   = m_center_y_reg;
    assign m_radius     = m_radius_reg;
    assign m_degenerate = m_degenerate_reg;

    a_degenerate_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_degenerate |->
            m_center_x == '0 && m_center_y == '0 && m_radius == '0)
        else $error("degenerate word with nonzero fields");

    a_stall_cause: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> m_valid && !m_ready && sq_valid)
        else $error("input stalled without a blocked output");

    a_accept_enters: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> v1_reg)
        else $error("accepted word missing from first stage");

endmodule
